// ----- rtl/core/imp_pkg.sv -----
// Shared constants and types for the integer matrix power core.
package imp_pkg;
  localparam int MaxSize = 8;
  localparam int ElemBits = 32;
  localparam int Cells = MaxSize * MaxSize;
  localparam int IdxBits = $clog2(Cells);
  localparam int DimBits = $clog2(MaxSize);
  localparam int CntBits = 7;

  localparam logic [0:0] RegMatrixSize = 1'd0;
  localparam logic [0:0] RegExponent = 1'd1;

  typedef struct packed {
    logic [ElemBits-1:0] value;
    logic [IdxBits-1:0]  addr;
    logic                done;
  } load_word_t;
endpackage

// ----- rtl/core/imp_front.sv -----
// Front end: counts incoming elements and tags the word that completes a matrix.
module imp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [3:0]                    size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [imp_pkg::ElemBits-1:0]  in_data_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output imp_pkg::load_word_t           q_word_o
);
  import imp_pkg::*;

  logic [CntBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic [DimBits:0]   n;
  logic [7:0]         cells;
  logic               fire;

  always_comb begin
    if (size_i == 4'd0) n = (DimBits+1)'(1);
    else if (size_i > 4'(MaxSize)) n = (DimBits+1)'(MaxSize);
    else n = (DimBits+1)'(size_i);
  end
  assign cells = 8'(n) * 8'(n);

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign fire       = in_valid_i && q_ready_i;
  assign cnt_inc    = cnt_q + CntBits'(1);

  always_comb begin
    q_word_o.value = in_data_i;
    q_word_o.addr  = cnt_q[IdxBits-1:0];
    q_word_o.done  = ({1'b0, cnt_inc} >= cells);
    cnt_d = cnt_q;
    if (fire) cnt_d = q_word_o.done ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
endmodule

// ----- rtl/core/imp_fifo.sv -----
// Two-entry queue between front end and compute engine.
module imp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  imp_pkg::load_word_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imp_pkg::load_word_t out_word_o
);
  import imp_pkg::*;

  load_word_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_word_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- rtl/core/imp_engine.sv -----
// Compute engine: stores the matrix, forms the power with one MAC, streams the result.
module imp_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [3:0]                    size_i,
  input  logic [15:0]                   exp_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  imp_pkg::load_word_t           q_word_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [imp_pkg::ElemBits-1:0]  m_data_o,
  output logic                          m_last_o
);
  import imp_pkg::*;

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StMac  = 3'd2;
  localparam logic [2:0] StCopy = 3'd3;
  localparam logic [2:0] StNext = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StRead = 3'd6;

  // Memories: source/base, running product, scratch.
  logic [ElemBits-1:0] base_mem [Cells];
  logic [ElemBits-1:0] run_mem  [Cells];
  logic [ElemBits-1:0] scr_mem  [Cells];

  logic [2:0]         st_q, st_d;
  logic [DimBits:0]   n_q;
  logic [15:0]        e_q;
  logic               sq_q;       // 1: base*base, 0: run*base
  logic               ph_q;       // 1: shift exponent and square next
  logic [DimBits-1:0] r_q, c_q, t_q;
  logic [IdxBits-1:0] ia, ib, ic, k_q;
  logic [IdxBits-1:0] dg_q;
  logic               cw_q;
  logic [IdxBits-1:0] ca_q;
  logic [ElemBits-1:0] a_q, b_q, acc_q, prod_q, rd_q, scr_rd_q;
  logic               pv_q, pl_q, pe_q;   // product valid, last term, first term
  logic [IdxBits-1:0] pdst_q;
  logic               ov_q, ol_q;
  logic [ElemBits-1:0] od_q;
  logic [DimBits:0]   n_now;
  logic               last_t, last_c, last_r, last_k;
  logic [IdxBits-1:0] cells_m1;

  always_comb begin
    if (size_i == 4'd0) n_now = (DimBits+1)'(1);
    else if (size_i > 4'(MaxSize)) n_now = (DimBits+1)'(MaxSize);
    else n_now = (DimBits+1)'(size_i);
  end

  function automatic logic [IdxBits-1:0] ix(logic [DimBits-1:0] r, logic [DimBits-1:0] c,
                                            logic [DimBits:0] n);
    logic [IdxBits:0] v;
    v = (IdxBits+1)'(r) * (IdxBits+1)'(n) + (IdxBits+1)'(c);
    return v[IdxBits-1:0];
  endfunction

  assign ia = ix(r_q, t_q, n_q);
  assign ib = ix(t_q, c_q, n_q);
  assign ic = ix(r_q, c_q, n_q);
  assign last_t = ({1'b0, t_q} == n_q - 1'b1);
  assign last_c = ({1'b0, c_q} == n_q - 1'b1);
  assign last_r = ({1'b0, r_q} == n_q - 1'b1);
  assign cells_m1 = IdxBits'(8'(n_q) * 8'(n_q) - 8'd1);
  assign last_k = (k_q == cells_m1);

  assign q_ready_o = (st_q == StLoad);
  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_last_o  = ol_q;

  // Operand reads (registered).
  always_ff @(posedge clk_i) begin
    a_q <= sq_q ? base_mem[ia] : run_mem[ia];
    b_q <= base_mem[ib];
    rd_q <= run_mem[k_q];
    scr_rd_q <= scr_mem[k_q];
  end

  // Multiplier and accumulator, plus the memory writes for load, identity init and copy-back.
  always_ff @(posedge clk_i) begin
    prod_q <= ElemBits'(a_q * b_q);
    if (pv_q) begin
      if (pl_q) scr_mem[pdst_q] <= (pe_q ? '0 : acc_q) + prod_q;
      acc_q <= (pe_q ? '0 : acc_q) + prod_q;
    end
    if (st_q == StLoad && q_valid_i) base_mem[q_word_i.addr] <= q_word_i.value;
    if (st_q == StInit)
      run_mem[k_q] <= (k_q == dg_q) ? ElemBits'(1) : '0;
    if (cw_q) begin
      if (sq_q) base_mem[ca_q] <= scr_rd_q;
      else run_mem[ca_q] <= scr_rd_q;
    end
  end

  // Pipeline tags for MAC: read stage then multiply stage.
  logic mv1_q, ml1_q, me1_q;
  logic [IdxBits-1:0] md1_q;

  // Sequencing: StNext decides whether to multiply run*base (e odd) or square base.
  logic mac_done, pipe_busy;
  assign mac_done  = last_t && last_c && last_r;
  assign pipe_busy = mv1_q || pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      n_q <= '0; e_q <= '0; sq_q <= 1'b0; ph_q <= 1'b0;
      r_q <= '0; c_q <= '0; t_q <= '0; k_q <= '0; dg_q <= '0;
      cw_q <= 1'b0; ca_q <= '0;
      mv1_q <= 1'b0; ml1_q <= 1'b0; me1_q <= 1'b0; md1_q <= '0;
      pv_q <= 1'b0; pl_q <= 1'b0; pe_q <= 1'b0; pdst_q <= '0;
      ov_q <= 1'b0; ol_q <= 1'b0; od_q <= '0;
    end else begin
      st_q <= st_d;
      mv1_q <= (st_q == StMac);
      ml1_q <= last_t; me1_q <= (t_q == '0); md1_q <= ic;
      pv_q <= mv1_q; pl_q <= ml1_q; pe_q <= me1_q; pdst_q <= md1_q;
      cw_q <= (st_q == StCopy) && !pipe_busy;
      ca_q <= k_q;
      case (st_q)
        StLoad: begin
          if (q_valid_i && q_word_i.done) begin
            n_q <= n_now; e_q <= exp_i; k_q <= '0;
            dg_q <= '0; ph_q <= 1'b0;
          end
        end
        StInit: begin
          k_q <= last_k ? '0 : k_q + 1'b1;
          if (k_q == dg_q) dg_q <= dg_q + IdxBits'(n_q) + IdxBits'(1);
        end
        StMac: begin
          t_q <= last_t ? '0 : t_q + 1'b1;
          if (last_t) begin
            c_q <= last_c ? '0 : c_q + 1'b1;
            if (last_c) r_q <= last_r ? '0 : r_q + 1'b1;
          end
          k_q <= '0;
        end
        StCopy: begin
          if (!pipe_busy) k_q <= last_k ? '0 : k_q + 1'b1;
        end
        StNext: begin
          if (!ph_q) begin
            if (e_q != '0) ph_q <= 1'b1;
            sq_q <= 1'b0;
          end else begin
            e_q <= e_q >> 1;
            ph_q <= 1'b0;
            sq_q <= 1'b1;
          end
          k_q <= '0;
        end
        StRead: begin
          // run_mem[k_q] read lands in rd_q next cycle
        end
        StOut: begin
          if (!ov_q || m_ready_i) begin
            ov_q <= 1'b1; od_q <= rd_q; ol_q <= last_k;
            k_q <= k_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (st_q != StOut && ov_q && m_ready_i) ov_q <= 1'b0;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StLoad: if (q_valid_i && q_word_i.done) st_d = StInit;
      StInit: if (last_k) st_d = StNext;
      StNext: begin
        if (!ph_q) begin
          if (e_q == '0) st_d = StRead;
          else if (e_q[0]) st_d = StMac;
        end else if ((e_q >> 1) != '0) st_d = StMac;
      end
      StMac: if (mac_done) st_d = StCopy;
      StCopy: if (!pipe_busy && last_k) st_d = StNext;
      StRead: st_d = StOut;
      StOut: begin
        if (!ov_q || m_ready_i) st_d = last_k ? StLoad : StRead;
      end
      default: st_d = StLoad;
    endcase
  end
endmodule

// ----- rtl/core/integer_matrix_power_core.sv -----
// Top level of the integer matrix power core.
// Usage:
//   s_axis carries matrix elements row-major, one 32-bit signed word each.
//   cfg_we_i/cfg_idx_i/cfg_data_i write matrix_size (index 0) and exponent
//   (index 1) while the core is idle.
//   When the word completing an n by n matrix arrives, the core loads the
//   identity and raises the matrix to the exponent by square-and-multiply
//   on a single multiply-accumulate unit, with up to two matrix multiplies
//   per exponent bit.
//   m_axis then delivers the n*n result words row-major, with tlast on the
//   final word. A stalled receiver holds the output word.
//   During loading s_axis takes one word per cycle; afterwards it takes up
//   to two more words into the queue, then stalls while the power is formed
//   and while the result drains.
//   Reset clears the load counter and the sequencer; sizes return to 1 and
//   the exponent to 1.
module integer_matrix_power_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // element_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value
  output logic        m_axis_tlast
);
  import imp_pkg::*;

  logic [3:0]  size_q;
  logic [15:0] exp_q;
  logic        fv, fr, ev, er;
  load_word_t  fw, ew;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd1;
      exp_q  <= 16'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegMatrixSize) size_q <= cfg_data_i[3:0];
      if (cfg_idx_i == RegExponent) exp_q <= cfg_data_i;
    end
  end

  imp_front u_front (
    .clk_i, .rst_ni, .size_i(size_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .q_valid_o(fv), .q_ready_i(fr), .q_word_o(fw)
  );

  imp_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(fv), .in_ready_o(fr), .in_word_i(fw),
    .out_valid_o(ev), .out_ready_i(er), .out_word_o(ew)
  );

  imp_engine u_engine (
    .clk_i, .rst_ni, .size_i(size_q), .exp_i(exp_q),
    .q_valid_i(ev), .q_ready_o(er), .q_word_i(ew),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_last_o(m_axis_tlast)
  );
endmodule

// ----- tb/sv/tb_integer_matrix_power_core.sv -----
// Testbench for the integer matrix power core: random matrices and powers checked by a scoreboard.
`timescale 1ns / 1ps

module tb_integer_matrix_power_core;
  import imp_pkg::*;

  localparam int unsigned IdleLimit = 400000;

  class power_scoreboard;
    logic [3:0]  size_reg;
    logic [15:0] exp_reg;
    logic [31:0] src[Cells];
    logic [6:0]  loaded;
    logic [32:0] result_q[$];

    function new();
      size_reg = 4'd1;
      exp_reg  = 16'd1;
      loaded   = '0;
      foreach (src[i]) src[i] = '0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] data);
      if (idx == RegMatrixSize) size_reg = data[3:0];
      else if (idx == RegExponent) exp_reg = data;
    endfunction

    function int unsigned dim();
      if (size_reg == 0) return 1;
      if (size_reg > MaxSize) return MaxSize;
      return size_reg;
    endfunction

    function void mat_mul(output logic [31:0] dst[Cells], input logic [31:0] a[Cells],
                          input logic [31:0] b[Cells], input int unsigned n);
      logic [31:0] acc;
      foreach (dst[i]) dst[i] = '0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          acc = '0;
          for (int t = 0; t < n; t++) acc = acc + a[r * n + t] * b[t * n + c];
          dst[r * n + c] = acc;
        end
    endfunction

    function void note_element(logic [31:0] value);
      int unsigned n;
      logic [31:0] power[Cells];
      logic [31:0] base[Cells];
      logic [31:0] tmp[Cells];
      logic [15:0] e;
      n = dim();
      if (loaded < Cells) src[loaded] = value;
      loaded = loaded + 7'd1;
      if (loaded < n * n) return;
      loaded = '0;
      foreach (power[i]) power[i] = '0;
      for (int i = 0; i < n; i++) power[i * n + i] = 32'd1;
      base = src;
      e = exp_reg;
      while (e != 0) begin
        if (e[0]) begin
          mat_mul(tmp, power, base, n);
          power = tmp;
        end
        e = e >> 1;
        if (e != 0) begin
          mat_mul(tmp, base, base, n);
          base = tmp;
        end
      end
      for (int i = 0; i < n * n; i++) result_q.push_back({i == n * n - 1, power[i]});
    endfunction

    function string check(logic [31:0] data, logic last);
      logic [32:0] want;
      if (result_q.size() == 0) return $sformatf("unexpected word %h last %b", data, last);
      want = result_q.pop_front();
      if (data !== want[31:0] || last !== want[32])
        return $sformatf("word %h last %b, expected %h last %b", data, last,
                         want[31:0], want[32]);
      return "";
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  power_scoreboard sb;
  int unsigned errors;
  int unsigned in_idle;
  int unsigned out_idle;
  int unsigned quiet_cycles;
  int unsigned items_sent;

  integer_matrix_power_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= out_idle);
      if (m_axis_tvalid && m_axis_tready) begin
        string msg;
        msg = sb.check(m_axis_tdata, m_axis_tlast);
        if (msg != "") report(msg);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("integer_matrix_power_core test failed");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] value);
    if ($urandom_range(99) < in_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_element(value);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(6) - 3;
    endcase
  endfunction

  task automatic send_matrix(logic [3:0] size, logic [15:0] exp);
    int unsigned n;
    write_reg(RegMatrixSize, size);
    write_reg(RegExponent, exp);
    n = sb.dim();
    for (int i = 0; i < n * n; i++) send_word(rand_elem());
  endtask

  initial begin
    logic [3:0] size;
    logic [15:0] exp;
    sb = new();
    errors = 0;
    in_idle = 0;
    out_idle = 0;
    items_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'h8000_0000);
    send_word(32'h7fff_ffff);
    send_matrix(4'd0, 16'd3);
    send_matrix(4'd15, 16'd1);
    send_matrix(4'd2, 16'd0);
    send_matrix(4'd1, 16'hffff);
    send_matrix(4'd3, 16'd2);
    write_reg(RegMatrixSize, 4'd3);
    for (int i = 0; i < 5; i++) send_word(rand_elem());
    write_reg(RegMatrixSize, 4'd2);
    send_word(32'hffff_ffff);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle = 0;  out_idle = 0;  end
        1: begin in_idle = 85; out_idle = 0;  end
        2: begin in_idle = 0;  out_idle = 85; end
        default: begin in_idle = 13; out_idle = 13; end
      endcase
      while (items_sent < 85 + 48 * (phase + 1)) begin
        case ($urandom_range(9))
          0: size = 4'd8;
          1: size = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
          default: size = 4'($urandom_range(3, 1));
        endcase
        if (size == 4'd1 || $urandom_range(9) == 0) exp = $urandom();
        else exp = $urandom_range(20);
        send_matrix(size, exp);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && sb.pending() == 0)
      $display("integer_matrix_power_core test passed");
    else
      $display("integer_matrix_power_core test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/imp_pkg.sv
rtl/core/imp_front.sv
rtl/core/imp_fifo.sv
rtl/core/imp_engine.sv
rtl/core/integer_matrix_power_core.sv
tb/sv/tb_integer_matrix_power_core.sv
